// ===== design/assert_macros.svh =====
// Assertion macros used by the frame receiver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SCFR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver assertion failed");

// Check that a condition implies another in the following cycle.
`define SCFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver assertion failed");

`endif

// ===== design/scfr_pkg.sv =====
// Package with shared constants and types of the SLIP checksum frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package scfr_pkg;

    // Default payload capacity in bytes
    localparam int PAYLOAD_DEPTH_DEF = 256;

    // Result queue depth
    localparam int RQ_DEPTH = 3;

    // Line bytes
    localparam logic [7:0] BYTE_END      = 8'hC0;
    localparam logic [7:0] BYTE_PROTO    = 8'h01;
    localparam logic [7:0] BYTE_ESC      = 8'hDB;
    localparam logic [7:0] BYTE_ESC_END  = 8'hDC;
    localparam logic [7:0] BYTE_ESC_ESC  = 8'hDD;

    // Checksum seed: 0x5555 plus the protocol byte
    localparam logic [15:0] SUM_SEED = 16'h5555 + 16'(BYTE_PROTO);

    // Commands
    localparam logic [1:0] CMD_RECEIVE = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_GOOD  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_OVER  = 3'd3;
    localparam logic [2:0] ST_DROP  = 3'd4;
    localparam logic [2:0] ST_ESC   = 3'd5;
    localparam logic [2:0] ST_INDEX = 3'd6;

    // Status flags of one result beat
    typedef struct packed {
        logic [2:0] status;
        logic       frame_ready;
    } res_flags_t;

    // Fill level of the result queue
    typedef struct packed {
        logic full;
        logic one_free;
    } rq_level_t;

endpackage

`default_nettype wire

// ===== design/slip_checksum_frame_receiver_top.sv =====
// Top level of the SLIP checksum frame receiver.
// The receiver takes one beat per clock cycle while in_stall is low: each
// beat needs one compare, one 16-bit add and one access to the payload
// store, whose registered read port sets the pipeline depth. A result is
// registered in the result stage alongside the read data and then waits
// in a three-entry result queue, so input stall is driven from registers
// only and rises when the queue and the read stage together hold three
// results. The payload store has no clearing pass and is usable right
// after reset; only entries written by the held frame can ever be read.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module slip_checksum_frame_receiver_top #(
    parameter int   PAYLOAD_DEPTH = scfr_pkg::PAYLOAD_DEPTH_DEF,
    localparam int  LEN_W         = $clog2(PAYLOAD_DEPTH + 3)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        command,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [LEN_W-1:0]  read_index,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [2:0]             status,
    output logic                   frame_ready,
    output logic [LEN_W-1:0]       frame_length,
    output logic [7:0]             read_data
);

    localparam int DW = 3 + 1 + LEN_W + 8;

    logic                  accept;
    logic                  res_valid;
    scfr_pkg::res_flags_t  res_flags;
    logic [LEN_W-1:0]      res_length;
    logic [7:0]            res_data;
    scfr_pkg::rq_level_t   level;
    logic [DW-1:0]         head_data;
    logic                  pop;

    // Stall while the queue cannot take every result in flight
    assign in_stall = level.full || (level.one_free && res_valid);
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    scfr_frame_engine #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .LEN_W         (LEN_W)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (command),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .res_valid  (res_valid),
        .res_flags  (res_flags),
        .res_length (res_length),
        .res_data   (res_data)
    );

    scfr_result_fifo #(
        .DW (DW)
    ) u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  ({res_flags, res_length, res_data}),
        .pop        (pop),
        .head_valid (out_valid),
        .head_data  (head_data),
        .level      (level)
    );

    // Unpack the head beat
    assign status       = head_data[DW-1 -: 3];
    assign frame_ready  = head_data[DW-4];
    assign frame_length = head_data[LEN_W+7 -: LEN_W];
    assign read_data    = head_data[7:0];

    `SCFR_ASSERT_IMPL(a_queue_no_overrun, level.full, !res_valid)
    `SCFR_ASSERT_IMPL(a_good_means_held, out_valid && status == scfr_pkg::ST_GOOD, frame_ready)
    `SCFR_ASSERT_IMPL(a_length_only_held, out_valid && !frame_ready, frame_length == '0)
    `SCFR_ASSERT_IMPL(a_data_only_on_read, out_valid && read_data != 8'd0,
                      status == scfr_pkg::ST_NONE && frame_ready)
    `SCFR_ASSERT_NEXT(a_accept_gives_result, accept, res_valid)

endmodule

`default_nettype wire

// ===== design/scfr_frame_engine.sv =====
// Deframing state, checksum and payload store with its read port.
`timescale 1ns / 1ps
`default_nettype none

module scfr_frame_engine #(
    parameter int PAYLOAD_DEPTH = scfr_pkg::PAYLOAD_DEPTH_DEF,
    parameter int LEN_W         = $clog2(PAYLOAD_DEPTH + 3)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [1:0]           command,
    input  wire logic [7:0]           rx_byte,
    input  wire logic [LEN_W-1:0]     read_index,
    output logic                      res_valid,
    output scfr_pkg::res_flags_t      res_flags,
    output logic [LEN_W-1:0]          res_length,
    output logic [7:0]                res_data
);

    localparam int STORE_DEPTH = PAYLOAD_DEPTH + 2;
    localparam int AW          = $clog2(STORE_DEPTH);

    // Receiver phases
    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_PROTO = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_ESC   = 2'd3;

    logic [1:0]       phase_reg,    phase_next;
    logic [LEN_W-1:0] count_reg,    count_next;
    logic [15:0]      sum_reg,      sum_next;
    logic             held_reg,     held_next;
    logic [LEN_W-1:0] held_len_reg, held_len_next;
    logic [7:0]       last1_reg,    last1_next;
    logic [7:0]       last2_reg,    last2_next;

    logic             s1_valid_reg;
    logic [2:0]       s1_status_reg;
    logic             s1_ready_reg;
    logic [LEN_W-1:0] s1_len_reg;
    logic             s1_rd_ok_reg;
    logic [7:0]       rd_data_reg;

    logic [2:0]       status_c;
    logic             rd_ok_c;
    logic             wr_en;
    logic [7:0]       wr_data;
    logic [7:0]       store_b;
    logic             do_store;

    logic [7:0]       store_mem [STORE_DEPTH];

    // Work out the next state for the beat on the input
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        held_next     = held_reg;
        held_len_next = held_len_reg;
        last1_next    = last1_reg;
        last2_next    = last2_reg;
        status_c      = scfr_pkg::ST_NONE;
        rd_ok_c       = 1'b0;
        do_store      = 1'b0;
        store_b       = rx_byte;
        wr_en         = 1'b0;

        unique case (command)
            scfr_pkg::CMD_RECEIVE:
            begin
                if (held_reg)
                begin
                    status_c = scfr_pkg::ST_DROP;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            if (rx_byte == scfr_pkg::BYTE_END)
                                phase_next = PH_PROTO;
                        end
                        PH_PROTO:
                        begin
                            if (rx_byte == scfr_pkg::BYTE_PROTO)
                            begin
                                count_next = '0;
                                sum_next   = scfr_pkg::SUM_SEED;
                                phase_next = PH_DATA;
                            end
                            else if (rx_byte != scfr_pkg::BYTE_END)
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                        PH_DATA:
                        begin
                            if (rx_byte == scfr_pkg::BYTE_END)
                            begin
                                // Close the frame and check the trailing sum bytes
                                if (count_reg < LEN_W'(2) ||
                                    last2_reg != sum_reg[7:0] ||
                                    last1_reg != sum_reg[15:8])
                                begin
                                    status_c   = scfr_pkg::ST_CHECK;
                                    phase_next = PH_PROTO;
                                end
                                else
                                begin
                                    status_c      = scfr_pkg::ST_GOOD;
                                    held_next     = 1'b1;
                                    held_len_next = count_reg - LEN_W'(2);
                                    phase_next    = PH_HUNT;
                                end
                            end
                            else if (rx_byte == scfr_pkg::BYTE_ESC)
                            begin
                                phase_next = PH_ESC;
                            end
                            else
                            begin
                                do_store = 1'b1;
                            end
                        end
                        PH_ESC:
                        begin
                            if (rx_byte == scfr_pkg::BYTE_ESC_END)
                            begin
                                do_store = 1'b1;
                                store_b  = scfr_pkg::BYTE_END;
                            end
                            else if (rx_byte == scfr_pkg::BYTE_ESC_ESC)
                            begin
                                do_store = 1'b1;
                                store_b  = scfr_pkg::BYTE_ESC;
                            end
                            else if (rx_byte == scfr_pkg::BYTE_END)
                            begin
                                status_c   = scfr_pkg::ST_ESC;
                                phase_next = PH_PROTO;
                            end
                            else
                            begin
                                status_c   = scfr_pkg::ST_ESC;
                                phase_next = PH_HUNT;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
            end
            scfr_pkg::CMD_READ:
            begin
                if (held_reg && read_index < held_len_reg)
                    rd_ok_c = 1'b1;
                else
                    status_c = scfr_pkg::ST_INDEX;
            end
            scfr_pkg::CMD_RELEASE:
            begin
                if (held_reg)
                begin
                    held_next     = 1'b0;
                    held_len_next = '0;
                    count_next    = '0;
                    phase_next    = PH_HUNT;
                end
            end
            default:
            begin
                status_c = scfr_pkg::ST_NONE;
            end
        endcase

        // Store a data byte, or drop the frame on overflow
        if (do_store)
        begin
            if (count_reg >= LEN_W'(STORE_DEPTH))
            begin
                status_c   = scfr_pkg::ST_OVER;
                count_next = '0;
                phase_next = PH_HUNT;
            end
            else
            begin
                wr_en      = 1'b1;
                count_next = count_reg + LEN_W'(1);
                if (count_reg >= LEN_W'(2))
                    sum_next = sum_reg + 16'(last2_reg);
                last2_next = last1_reg;
                last1_next = store_b;
                phase_next = PH_DATA;
            end
        end
    end

    assign wr_data = store_b;

    // Hold receiver control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            count_reg    <= '0;
            sum_reg      <= '0;
            held_reg     <= 1'b0;
            held_len_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            held_reg     <= held_next;
            held_len_reg <= held_len_next;
        end
    end

    // Track the two most recent stored bytes for the trailing sum check
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last1_reg <= last1_next;
            last2_reg <= last2_next;
        end
    end

    // Payload store: one write and one registered read per cycle, on accepted beats only
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
            store_mem[count_reg[AW-1:0]] <= wr_data;
        if (accept && command == scfr_pkg::CMD_READ)
            rd_data_reg <= store_mem[read_index[AW-1:0]];
    end

    // Result stage, aligned with the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status_c;
            s1_ready_reg  <= held_next;
            s1_len_reg    <= held_next ? held_len_next : '0;
            s1_rd_ok_reg  <= rd_ok_c;
        end
    end

    assign res_valid             = s1_valid_reg;
    assign res_flags.status      = s1_status_reg;
    assign res_flags.frame_ready = s1_ready_reg;
    assign res_length            = s1_len_reg;
    assign res_data              = s1_rd_ok_reg ? rd_data_reg : 8'd0;

endmodule

`default_nettype wire

// ===== design/scfr_result_fifo.sv =====
// Small result queue that parts the output side from the input side.
`timescale 1ns / 1ps
`default_nettype none

module scfr_result_fifo #(
    parameter int DW = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DW-1:0]     push_data,
    input  wire logic              pop,
    output logic                   head_valid,
    output logic [DW-1:0]          head_data,
    output scfr_pkg::rq_level_t    level
);

    localparam int PW = $clog2(scfr_pkg::RQ_DEPTH);
    localparam int CW = $clog2(scfr_pkg::RQ_DEPTH + 1);

    logic [DW-1:0] entry_reg [scfr_pkg::RQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(scfr_pkg::RQ_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(scfr_pkg::RQ_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the queued beats
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign head_valid     = (count_reg != '0);
    assign head_data      = entry_reg[rd_ptr_reg];
    assign level.full     = (count_reg == CW'(scfr_pkg::RQ_DEPTH));
    assign level.one_free = (count_reg == CW'(scfr_pkg::RQ_DEPTH - 1));

endmodule

`default_nettype wire
